// ----- design/spsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types, constants and the commutation table of the six-step
// commutator.
// ----------------------------------------------------------------------------
package spsc_pkg;

    localparam int WIDTH_W   = 16;
    localparam int GAIN_W    = 8;
    localparam int PROD_W    = WIDTH_W + GAIN_W;
    localparam int CMP_W     = 11;
    localparam int STEP_W    = 3;
    localparam int DRIVE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int DUTY_SHIFT = 5;

    localparam logic [WIDTH_W-1:0] DUTY_MAX  = 16'hFFFF;
    localparam logic [STEP_W-1:0]  LAST_STEP = 3'd5;
    localparam logic [STEP_W-1:0]  FIRST_STEP = 3'd0;

    // command codes
    localparam logic CMD_PULSE   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // phase drive codes
    localparam logic [DRIVE_W-1:0] DRIVE_FLOAT = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_LOW   = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_PWM   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESH = 3'd5;

    // register reset values
    localparam logic [WIDTH_W-1:0] RST_REJECT_LOW  = 16'd500;
    localparam logic [WIDTH_W-1:0] RST_REJECT_HIGH = 16'd3000;
    localparam logic [WIDTH_W-1:0] RST_CLAMP_LOW   = 16'd1000;
    localparam logic [WIDTH_W-1:0] RST_CLAMP_HIGH  = 16'd2000;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 8'd65;
    localparam logic [WIDTH_W-1:0] RST_STOP_THRESH = 16'd5000;

    typedef struct packed {
        logic [WIDTH_W-1:0] reject_low;
        logic [WIDTH_W-1:0] reject_high;
        logic [WIDTH_W-1:0] clamp_low;
        logic [WIDTH_W-1:0] clamp_high;
        logic [GAIN_W-1:0]  gain;
        logic [WIDTH_W-1:0] stop_threshold;
    } cfg_t;

    typedef struct packed {
        logic             rejected;
        logic             stopped;
        logic [CMP_W-1:0] compare;
    } duty_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] u;
        logic [DRIVE_W-1:0] v;
        logic [DRIVE_W-1:0] w;
    } drive_t;

    function automatic drive_t step_drive(input logic [STEP_W-1:0] step);
        drive_t d;
        unique case (step)
            3'd0:    d = '{u: DRIVE_LOW,   v: DRIVE_PWM,   w: DRIVE_FLOAT};
            3'd1:    d = '{u: DRIVE_FLOAT, v: DRIVE_PWM,   w: DRIVE_LOW};
            3'd2:    d = '{u: DRIVE_PWM,   v: DRIVE_FLOAT, w: DRIVE_LOW};
            3'd3:    d = '{u: DRIVE_PWM,   v: DRIVE_LOW,   w: DRIVE_FLOAT};
            3'd4:    d = '{u: DRIVE_FLOAT, v: DRIVE_LOW,   w: DRIVE_PWM};
            3'd5:    d = '{u: DRIVE_LOW,   v: DRIVE_FLOAT, w: DRIVE_PWM};
            default: d = '{u: DRIVE_LOW,   v: DRIVE_PWM,   w: DRIVE_FLOAT};
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- design/spsc_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_item_if
// Input item channel: command and measured pulse width.
// ----------------------------------------------------------------------------
interface spsc_item_if
    import spsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [WIDTH_W-1:0] pulse_width;

    modport source (output valid, output cmd, output pulse_width, input ready);
    modport sink   (input valid, input cmd, input pulse_width, output ready);
endinterface
`default_nettype wire

// ----- design/spsc_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_result_if
// Result channel: phase drives, compare value and step number.
// ----------------------------------------------------------------------------
interface spsc_result_if
    import spsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] phase_u;
    logic [DRIVE_W-1:0] phase_v;
    logic [DRIVE_W-1:0] phase_w;
    logic [CMP_W-1:0]   compare;
    logic [STEP_W-1:0]  step_index;

    modport source (output valid, output phase_u, output phase_v, output phase_w,
                    output compare, output step_index, input ready);
    modport sink   (input valid, input phase_u, input phase_v, input phase_w,
                    input compare, input step_index, output ready);
endinterface
`default_nettype wire

// ----- design/spsc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spsc_cfg_if
    import spsc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/spsc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module spsc_cfg_regs
    import spsc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    spsc_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                REG_REJECT_LOW:  cfg_next.reject_low     = cfg.data;
                REG_REJECT_HIGH: cfg_next.reject_high    = cfg.data;
                REG_CLAMP_LOW:   cfg_next.clamp_low      = cfg.data;
                REG_CLAMP_HIGH:  cfg_next.clamp_high     = cfg.data;
                REG_GAIN:        cfg_next.gain           = cfg.data[GAIN_W-1:0];
                REG_STOP_THRESH: cfg_next.stop_threshold = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reject_low     <= RST_REJECT_LOW;
            cfg_reg.reject_high    <= RST_REJECT_HIGH;
            cfg_reg.clamp_low      <= RST_CLAMP_LOW;
            cfg_reg.clamp_high     <= RST_CLAMP_HIGH;
            cfg_reg.gain           <= RST_GAIN;
            cfg_reg.stop_threshold <= RST_STOP_THRESH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/spsc_duty.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spsc_duty
// Reject window, clamp, offset, gain with saturation and stop decision.
// ----------------------------------------------------------------------------
module spsc_duty
    import spsc_pkg::*;
(
    input  wire logic [WIDTH_W-1:0] pulse_width,
    input  wire cfg_t               regs,
    output duty_t                   duty
);

    logic [WIDTH_W-1:0] w_lo;
    logic [WIDTH_W-1:0] w_clamped;
    logic [WIDTH_W-1:0] diff;
    logic [PROD_W-1:0]  product;
    logic [WIDTH_W-1:0] scaled;

    always_comb
    begin
        w_lo      = (pulse_width < regs.clamp_low) ? regs.clamp_low : pulse_width;
        w_clamped = (w_lo > regs.clamp_high) ? regs.clamp_high : w_lo;
        diff      = (w_clamped > regs.clamp_low) ? (w_clamped - regs.clamp_low)
                                                 : '0;
        product   = {{GAIN_W{1'b0}}, diff} * {{WIDTH_W{1'b0}}, regs.gain};
        scaled    = (product[PROD_W-1:WIDTH_W] != '0) ? DUTY_MAX
                                                      : product[WIDTH_W-1:0];

        duty.rejected = (pulse_width < regs.reject_low) ||
                        (pulse_width > regs.reject_high);
        duty.stopped  = scaled < regs.stop_threshold;
        duty.compare  = duty.stopped ? '0 : scaled[WIDTH_W-1:DUTY_SHIFT];
    end

endmodule
`default_nettype wire

// ----- design/servo_pulse_six_step_commutator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_pulse_six_step_commutator_core
// Six-step commutator steered by servo pulse widths and advance commands.
// The input register holds each item and feeds the result register.
// Throughput: one item per cycle while the result side does not stall.
// A rejected pulse width leaves the input register without a result.
// Reset (async, active low) clears valids, step 0, held compare 0, and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module servo_pulse_six_step_commutator_core
    import spsc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    spsc_item_if.sink    item,
    spsc_result_if.source result,
    spsc_cfg_if.sink     cfg
);

    cfg_t               regs;
    duty_t              duty;
    drive_t             drive;

    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [WIDTH_W-1:0] s1_width_reg;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [CMP_W-1:0]   held_reg;
    logic [CMP_W-1:0]   held_next;

    logic               out_valid_reg;
    drive_t             out_drive_reg;
    logic [CMP_W-1:0]   out_cmp_reg;
    logic [STEP_W-1:0]  out_step_reg;

    logic               out_free;
    logic               s1_produces;
    logic               s1_leave;
    logic               in_xfer;
    logic               floating;

    spsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    spsc_duty u_duty (
        .pulse_width (s1_width_reg),
        .regs        (regs),
        .duty        (duty)
    );

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_produces = (s1_cmd_reg == CMD_ADVANCE) || !duty.rejected;
    assign s1_leave    = s1_valid_reg && (!s1_produces || out_free);
    assign item.ready  = !s1_valid_reg || s1_leave;
    assign in_xfer     = item.valid && item.ready;

    always_comb
    begin
        step_next = step_reg;
        held_next = held_reg;
        floating  = 1'b0;
        if (s1_cmd_reg == CMD_ADVANCE)
        begin
            step_next = (step_reg >= LAST_STEP) ? FIRST_STEP : step_reg + 3'd1;
        end
        else
        begin
            held_next = duty.compare;
            floating  = duty.stopped;
        end
        drive = floating ? drive_t'{u: DRIVE_FLOAT, v: DRIVE_FLOAT, w: DRIVE_FLOAT}
                         : step_drive(step_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= FIRST_STEP;
            held_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s1_leave && s1_produces)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
                held_reg      <= held_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg   <= item.cmd;
            s1_width_reg <= item.pulse_width;
        end
        if (s1_leave && s1_produces)
        begin
            out_drive_reg <= drive;
            out_cmp_reg   <= held_next;
            out_step_reg  <= step_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.phase_u    = out_drive_reg.u;
    assign result.phase_v    = out_drive_reg.v;
    assign result.phase_w    = out_drive_reg.w;
    assign result.compare    = out_cmp_reg;
    assign result.step_index = out_step_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("commutation step out of range");

    a_out_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_step_reg <= LAST_STEP)
        else $error("result step out of range");

    a_float_zero_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_drive_reg.u == DRIVE_FLOAT &&
         out_drive_reg.v == DRIVE_FLOAT && out_drive_reg.w == DRIVE_FLOAT)
        |-> out_cmp_reg == '0)
        else $error("floating phases with nonzero compare");

    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> s1_valid_reg)
        else $error("transferred item lost at input register");

    a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_leave && s1_cmd_reg == CMD_ADVANCE) |=> step_reg != $past(step_reg))
        else $error("advance did not move the step");
`endif

endmodule
`default_nettype wire

// ----- tb/commutation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// commutation_checker
// Watches the item, result and register write channels of the six-step
// commutator. It keeps its own copy of the registers, step and held compare,
// works out the result, if any, of each accepted item and checks every result
// transfer against the oldest one still due.
// ----------------------------------------------------------------------------
module commutation_checker
    import spsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    spsc_item_if      item,
    spsc_result_if    result,
    spsc_cfg_if       cfg,
    output int        mismatches,
    output int        pending
);

    typedef struct packed {
        drive_t             drive;
        logic [CMP_W-1:0]   compare;
        logic [STEP_W-1:0]  step;
    } commutation_out_t;

    localparam drive_t ALL_FLOAT = '{u: DRIVE_FLOAT, v: DRIVE_FLOAT, w: DRIVE_FLOAT};

    cfg_t                regs;
    logic [STEP_W-1:0]   step_now;
    logic [CMP_W-1:0]    held_cmp;
    commutation_out_t    due_results[$];
    commutation_out_t    want;

    initial mismatches = 0;

    function automatic drive_t phases_for_step(input logic [STEP_W-1:0] s);
        drive_t d;
        case (s)
            3'd0:    d = '{u: DRIVE_LOW,   v: DRIVE_PWM,   w: DRIVE_FLOAT};
            3'd1:    d = '{u: DRIVE_FLOAT, v: DRIVE_PWM,   w: DRIVE_LOW};
            3'd2:    d = '{u: DRIVE_PWM,   v: DRIVE_FLOAT, w: DRIVE_LOW};
            3'd3:    d = '{u: DRIVE_PWM,   v: DRIVE_LOW,   w: DRIVE_FLOAT};
            3'd4:    d = '{u: DRIVE_FLOAT, v: DRIVE_LOW,   w: DRIVE_PWM};
            3'd5:    d = '{u: DRIVE_LOW,   v: DRIVE_FLOAT, w: DRIVE_PWM};
            default: d = ALL_FLOAT;
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t ns: %s got %0d, wanted %0d", $time, what, got, exp_val);
    endtask

    task automatic predict_commutation(input logic c, input logic [WIDTH_W-1:0] width);
        logic [WIDTH_W-1:0] w;
        logic [WIDTH_W-1:0] diff;
        logic [PROD_W-1:0]  duty;
        logic               stopped;
        commutation_out_t   r;
        if (c == CMD_ADVANCE)
        begin
            step_now = (step_now >= LAST_STEP) ? FIRST_STEP : step_now + 3'd1;
            r.drive = phases_for_step(step_now);
            r.compare = held_cmp;
            r.step = step_now;
            due_results.push_back(r);
        end
        else if (width >= regs.reject_low && width <= regs.reject_high)
        begin
            // low clamp first, so crossed bounds end at clamp_high
            w = width;
            if (w < regs.clamp_low)
                w = regs.clamp_low;
            if (w > regs.clamp_high)
                w = regs.clamp_high;
            diff = (w > regs.clamp_low) ? w - regs.clamp_low : '0;
            duty = diff * regs.gain;
            if (duty > PROD_W'(DUTY_MAX))
                duty = PROD_W'(DUTY_MAX);
            stopped = duty < PROD_W'(regs.stop_threshold);
            held_cmp = stopped ? '0 : duty[DUTY_SHIFT +: CMP_W];
            r.drive = stopped ? ALL_FLOAT : phases_for_step(step_now);
            r.compare = held_cmp;
            r.step = step_now;
            due_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.reject_low     = RST_REJECT_LOW;
            regs.reject_high    = RST_REJECT_HIGH;
            regs.clamp_low      = RST_CLAMP_LOW;
            regs.clamp_high     = RST_CLAMP_HIGH;
            regs.gain           = RST_GAIN;
            regs.stop_threshold = RST_STOP_THRESH;
            step_now = FIRST_STEP;
            held_cmp = '0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_REJECT_LOW:  regs.reject_low     = cfg.data;
                    REG_REJECT_HIGH: regs.reject_high    = cfg.data;
                    REG_CLAMP_LOW:   regs.clamp_low      = cfg.data;
                    REG_CLAMP_HIGH:  regs.clamp_high     = cfg.data;
                    REG_GAIN:        regs.gain           = cfg.data[GAIN_W-1:0];
                    REG_STOP_THRESH: regs.stop_threshold = cfg.data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with nothing due, compare", result.compare, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (result.phase_u !== want.drive.u)
                        report_mismatch("phase_u", result.phase_u, want.drive.u);
                    if (result.phase_v !== want.drive.v)
                        report_mismatch("phase_v", result.phase_v, want.drive.v);
                    if (result.phase_w !== want.drive.w)
                        report_mismatch("phase_w", result.phase_w, want.drive.w);
                    if (result.compare !== want.compare)
                        report_mismatch("compare", result.compare, want.compare);
                    if (result.step_index !== want.step)
                        report_mismatch("step_index", result.step_index, want.step);
                end
            end
            if (item.valid && item.ready)
                predict_commutation(item.cmd, item.pulse_width);
            pending <= due_results.size();
        end
    end

endmodule

// ----- tb/servo_pulse_six_step_commutator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pulse_six_step_commutator_core_tb
// Drives pulse width and advance items into the commutator under a series of
// register settings, reset and extreme ones first and random ones after, with random gaps
// on the item side and random stalls on the result side. Checking is done by
// the commutation checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module servo_pulse_six_step_commutator_core_tb;
    import spsc_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   items_sent;
    int   quiet_cycles;
    bit   steady_sender;
    bit   steady_sink;
    cfg_t cur_regs;

    spsc_item_if   item_ch();
    spsc_result_if result_ch();
    spsc_cfg_if    cfg_ch();

    servo_pulse_six_step_commutator_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    commutation_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // no transfer on any channel for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stall before each transfer
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = steady_sink ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic send_item(input logic c, input logic [WIDTH_W-1:0] w);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.pulse_width <= w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a rejected width may still sit in the input stage
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic load_regs(input cfg_t r);
        logic [CFG_DAT_W-GAIN_W-1:0] upper;
        logic [CFG_IDX_W-1:0]        unmapped;
        upper = $urandom;
        unmapped = REG_STOP_THRESH + CFG_IDX_W'($urandom_range(1, 2));
        write_reg(REG_REJECT_LOW, r.reject_low);
        write_reg(REG_REJECT_HIGH, r.reject_high);
        write_reg(REG_CLAMP_LOW, r.clamp_low);
        write_reg(REG_CLAMP_HIGH, r.clamp_high);
        write_reg(REG_GAIN, {upper, r.gain});
        write_reg(REG_STOP_THRESH, r.stop_threshold);
        // indexes past the last register are ignored
        if ($urandom_range(0, 1) == 1)
            write_reg(unmapped, CFG_DAT_W'($urandom));
        cfg_ch.valid <= 1'b0;
        cur_regs = r;
    endtask

    task automatic random_regs();
        cfg_t r;
        int   k;
        k = $urandom_range(0, 9);
        if (k < 2)
        begin
            r.reject_low     = $urandom;
            r.reject_high    = $urandom;
            r.clamp_low      = $urandom;
            r.clamp_high     = $urandom;
            r.gain           = $urandom;
            r.stop_threshold = $urandom;
        end
        else
        begin
            r.clamp_low      = $urandom_range(0, 3000);
            r.clamp_high     = r.clamp_low + $urandom_range(0, 4000);
            r.reject_low     = $urandom_range(0, r.clamp_low);
            r.reject_high    = $urandom_range(r.clamp_high, 65535);
            r.gain           = $urandom_range(0, 255);
            r.stop_threshold = (k == 2) ? 16'd0 : (k == 3) ? 16'hFFFF : $urandom_range(0, 20000);
        end
        load_regs(r);
    endtask

    task automatic send_random_item();
        int                 k;
        logic [WIDTH_W-1:0] w;
        logic [WIDTH_W-1:0] boundary;
        k = $urandom_range(0, 99);
        w = $urandom;
        if (k < 20)
            send_item(CMD_ADVANCE, w);
        else
        begin
            if (k < 55)
                w = $urandom_range(cur_regs.clamp_low, cur_regs.clamp_high);
            else if (k < 75)
                w = $urandom_range(cur_regs.reject_low, cur_regs.reject_high);
            else if (k < 90)
            begin
                case ($urandom_range(0, 3))
                    0:       boundary = cur_regs.reject_low;
                    1:       boundary = cur_regs.reject_high;
                    2:       boundary = cur_regs.clamp_low;
                    default: boundary = cur_regs.clamp_high;
                endcase
                w = boundary + WIDTH_W'($urandom_range(0, 2)) - 16'd1;
            end
            send_item(CMD_PULSE, w);
        end
    endtask

    task automatic run_phase(input int n);
        steady_sender = ($urandom_range(0, 3) == 0);
        steady_sink = ($urandom_range(0, 3) == 0);
        repeat (n)
        begin
            send_random_item();
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_PULSE;
        item_ch.pulse_width <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_REJECT_LOW;
        cfg_ch.data <= '0;
        items_sent = 0;
        quiet_cycles = 0;
        steady_sender = 1'b0;
        steady_sink = 1'b0;
        cur_regs = '{reject_low: RST_REJECT_LOW, reject_high: RST_REJECT_HIGH,
                     clamp_low: RST_CLAMP_LOW, clamp_high: RST_CLAMP_HIGH,
                     gain: RST_GAIN, stop_threshold: RST_STOP_THRESH};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: step wrap, reject edges, clamps, stop edge
        send_item(CMD_ADVANCE, 16'hFFFF);
        repeat (5) send_item(CMD_ADVANCE, 16'h0000);
        send_item(CMD_ADVANCE, 16'hA5A5);
        send_item(CMD_PULSE, 16'd0);
        send_item(CMD_PULSE, 16'd499);
        send_item(CMD_PULSE, 16'd500);
        send_item(CMD_PULSE, 16'd3000);
        send_item(CMD_PULSE, 16'd3001);
        send_item(CMD_PULSE, 16'hFFFF);
        send_item(CMD_PULSE, 16'd1077);
        send_item(CMD_ADVANCE, 16'd0);
        send_item(CMD_PULSE, 16'd1076);
        send_item(CMD_ADVANCE, 16'd0);
        send_item(CMD_PULSE, 16'd1500);
        send_item(CMD_PULSE, 16'd2000);
        send_item(CMD_PULSE, 16'd1000);
        send_item(CMD_ADVANCE, 16'd1);
        drain_results();

        // extreme settings: full window with overflow, all zero, all max,
        // crossed clamps, empty window, threshold above every duty
        load_regs('{reject_low: 16'd0, reject_high: 16'hFFFF, clamp_low: 16'd0,
                    clamp_high: 16'hFFFF, gain: 8'hFF, stop_threshold: 16'd0});
        run_phase(40);
        load_regs('{reject_low: 16'd0, reject_high: 16'd0, clamp_low: 16'd0,
                    clamp_high: 16'd0, gain: 8'd0, stop_threshold: 16'd0});
        send_item(CMD_PULSE, 16'd0);
        run_phase(30);
        load_regs('{reject_low: 16'hFFFF, reject_high: 16'hFFFF, clamp_low: 16'hFFFF,
                    clamp_high: 16'hFFFF, gain: 8'hFF, stop_threshold: 16'hFFFF});
        send_item(CMD_PULSE, 16'hFFFF);
        run_phase(30);
        load_regs('{reject_low: 16'd0, reject_high: 16'hFFFF, clamp_low: 16'd3000,
                    clamp_high: 16'd1000, gain: 8'd40, stop_threshold: 16'd100});
        run_phase(40);
        load_regs('{reject_low: 16'd2000, reject_high: 16'd1000, clamp_low: 16'd1000,
                    clamp_high: 16'd2000, gain: 8'd65, stop_threshold: 16'd5000});
        run_phase(30);
        load_regs('{reject_low: 16'd0, reject_high: 16'hFFFF, clamp_low: 16'd0,
                    clamp_high: 16'd4000, gain: 8'd16, stop_threshold: 16'hFFFF});
        run_phase(40);

        while (items_sent < ITEM_TARGET)
        begin
            random_regs();
            run_phase($urandom_range(60, 200));
        end

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
